FILE: rtl/core/lfust_pkg.sv
package lfust_pkg;

   localparam int CSR_WIDTH      = 5;
   localparam int COUNT_WIDTH    = 16;
   localparam int AGE_WIDTH      = 32;
   localparam int SLOT_OUT_WIDTH = 4;
   localparam int EVICT_WIDTH    = 16;
   localparam int ACTION_WIDTH   = 2;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [AGE_WIDTH-1:0]   AGE_MAX   = '1;

   localparam logic [ACTION_WIDTH-1:0] ACT_HIT     = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_FILL    = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_REPLACE = 2'd2;

   // Status that travels with the search word from cell to cell.
   typedef struct packed {
      logic valid;
      logic hit;
      logic best_valid;
   } lfust_flags_type;

   // Write-back command broadcast to every cell at the end of an item.
   typedef struct packed {
      logic valid;
      logic fill;
      logic bump;
   } lfust_upd_type;

endpackage

FILE: rtl/core/lfust_cell.sv
module lfust_cell
   import lfust_pkg::*;
#(
   parameter int INDEX    = 0,
   parameter int ID_WIDTH = 16,
   parameter int IDX_W    = 4,
   parameter int CNT_W    = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CNT_W-1:0]       live,
   input  logic [CNT_W-1:0]       active,
   input  lfust_flags_type        flags_in,
   input  logic [ID_WIDTH-1:0]    id_in,
   input  logic [IDX_W-1:0]       hit_idx_in,
   input  logic [COUNT_WIDTH-1:0] hit_cnt_in,
   input  logic [IDX_W-1:0]       best_idx_in,
   input  logic [COUNT_WIDTH-1:0] best_cnt_in,
   input  logic [AGE_WIDTH-1:0]   best_age_in,
   input  logic [ID_WIDTH-1:0]    best_id_in,
   output lfust_flags_type        flags_out,
   output logic [ID_WIDTH-1:0]    id_out,
   output logic [IDX_W-1:0]       hit_idx_out,
   output logic [COUNT_WIDTH-1:0] hit_cnt_out,
   output logic [IDX_W-1:0]       best_idx_out,
   output logic [COUNT_WIDTH-1:0] best_cnt_out,
   output logic [AGE_WIDTH-1:0]   best_age_out,
   output logic [ID_WIDTH-1:0]    best_id_out,
   input  lfust_upd_type          upd,
   input  logic [IDX_W-1:0]       upd_slot,
   input  logic [ID_WIDTH-1:0]    upd_id
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX);

   logic [ID_WIDTH-1:0]    slot_id_ff;
   logic [COUNT_WIDTH-1:0] slot_cnt_ff;
   logic [AGE_WIDTH-1:0]   slot_age_ff;

   lfust_flags_type        flags_in_nx;
   lfust_flags_type        flags_ff;
   logic [ID_WIDTH-1:0]    id_ff;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in_nx;
   logic [COUNT_WIDTH-1:0] hit_cnt_ff, hit_cnt_in_nx;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in_nx;
   logic [COUNT_WIDTH-1:0] best_cnt_ff, best_cnt_in_nx;
   logic [AGE_WIDTH-1:0]   best_age_ff, best_age_in_nx;
   logic [ID_WIDTH-1:0]    best_id_ff, best_id_in_nx;
   logic                   in_live;
   logic                   in_active;

   assign in_live   = MY_POS < live;
   assign in_active = MY_POS < active;

   // Fold this slot into the passing search word: first match wins,
   // and the minimum prefers lower count, then greater age, then lower index.
   always_comb begin
      flags_in_nx    = flags_in;
      hit_idx_in_nx  = hit_idx_in;
      hit_cnt_in_nx  = hit_cnt_in;
      best_idx_in_nx = best_idx_in;
      best_cnt_in_nx = best_cnt_in;
      best_age_in_nx = best_age_in;
      best_id_in_nx  = best_id_in;
      if (flags_in.valid) begin
         if (in_live && !flags_in.hit) begin
            if (slot_id_ff == id_in) begin
               flags_in_nx.hit = 1'b1;
               hit_idx_in_nx   = MY_IDX;
               hit_cnt_in_nx   = slot_cnt_ff;
            end
         end
         if (in_active) begin
            if (!flags_in.best_valid || slot_cnt_ff < best_cnt_in ||
                (slot_cnt_ff == best_cnt_in && slot_age_ff > best_age_in)) begin
               flags_in_nx.best_valid = 1'b1;
               best_idx_in_nx = MY_IDX;
               best_cnt_in_nx = slot_cnt_ff;
               best_age_in_nx = slot_age_ff;
               best_id_in_nx  = slot_id_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in_nx;
      end
   end

   always_ff @(posedge clock) begin
      id_ff       <= id_in;
      hit_idx_ff  <= hit_idx_in_nx;
      hit_cnt_ff  <= hit_cnt_in_nx;
      best_idx_ff <= best_idx_in_nx;
      best_cnt_ff <= best_cnt_in_nx;
      best_age_ff <= best_age_in_nx;
      best_id_ff  <= best_id_in_nx;
   end

   // Every slot ages on each write-back; a freshly written slot ends at age one.
   always_ff @(posedge clock) begin
      if (upd.valid) begin
         if (upd_slot == MY_IDX && upd.fill) begin
            slot_id_ff  <= upd_id;
            slot_cnt_ff <= COUNT_WIDTH'(1);
            slot_age_ff <= AGE_WIDTH'(1);
         end else begin
            if (slot_age_ff != AGE_MAX) begin
               slot_age_ff <= slot_age_ff + AGE_WIDTH'(1);
            end
            if (upd_slot == MY_IDX && upd.bump && slot_cnt_ff != COUNT_MAX) begin
               slot_cnt_ff <= slot_cnt_ff + COUNT_WIDTH'(1);
            end
         end
      end
   end

   assign flags_out    = flags_ff;
   assign id_out       = id_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign hit_cnt_out  = hit_cnt_ff;
   assign best_idx_out = best_idx_ff;
   assign best_cnt_out = best_cnt_ff;
   assign best_age_out = best_age_ff;
   assign best_id_out  = best_id_ff;

endmodule

FILE: rtl/core/lfu_slot_table_oldest_tiebreak.sv
// LFU slot table with oldest-first tie-break. Each request word carries one id; the
// table answers with the slot that was hit, filled or replaced, the action, the id
// that was evicted and the slot's new use count. The slots form a row of cells, and
// a search word walks the row one cell per clock, collecting the first match and the
// least-used, oldest slot. An item walks the chain, its decision settles in the
// pending registers, and then it is written back into the cells as the response
// register is loaded; the write-back waits while an earlier response is not yet
// taken. The next request is taken in the cycle after the write-back, even while
// the response is still waiting to be taken. csr_slots_in_use selects how many
// slots are used; 0 acts as 1 and values above SLOTS act as SLOTS.
module lfu_slot_table_oldest_tiebreak
   import lfust_pkg::*;
#(
   parameter int SLOTS    = 16,
   parameter int ID_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_WIDTH-1:0]      csr_slots_in_use,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ID_WIDTH-1:0]       req_candidate_id,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SLOT_OUT_WIDTH-1:0] rsp_slot_index,
   output logic [ACTION_WIDTH-1:0]   rsp_action,
   output logic [EVICT_WIDTH-1:0]    rsp_evicted_id,
   output logic [COUNT_WIDTH-1:0]    rsp_use_count
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int NW    = (CNT_W > CSR_WIDTH) ? CNT_W : CSR_WIDTH;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [CSR_WIDTH-1:0]   csr_slots_ff;
   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       filled_ff, filled_in;
   logic [CNT_W-1:0]       active;
   logic [CNT_W-1:0]       live;
   logic [NW-1:0]          csr_ext;

   logic [IDX_W-1:0]       pend_slot_ff, pend_slot_in;
   logic [ACTION_WIDTH-1:0] pend_action_ff, pend_action_in;
   logic [ID_WIDTH-1:0]    pend_evict_ff, pend_evict_in;
   logic [COUNT_WIDTH-1:0] pend_count_ff, pend_count_in;
   logic [ID_WIDTH-1:0]    pend_id_ff, pend_id_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SLOT_OUT_WIDTH-1:0] rsp_slot_ff, rsp_slot_in;
   logic [ACTION_WIDTH-1:0] rsp_action_ff, rsp_action_in;
   logic [EVICT_WIDTH-1:0] rsp_evict_ff, rsp_evict_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic                   out_free;
   logic                   accept;
   lfust_upd_type          upd;
   logic [IDX_W-1:0]       upd_slot;
   logic [ID_WIDTH-1:0]    upd_id;

   logic [SLOT_OUT_WIDTH+IDX_W-1:0]    slot_wide;
   logic [EVICT_WIDTH+ID_WIDTH-1:0]    evict_wide;

   lfust_flags_type        tok_flags    [SLOTS+1];
   logic [ID_WIDTH-1:0]    tok_id       [SLOTS+1];
   logic [IDX_W-1:0]       tok_hit_idx  [SLOTS+1];
   logic [COUNT_WIDTH-1:0] tok_hit_cnt  [SLOTS+1];
   logic [IDX_W-1:0]       tok_best_idx [SLOTS+1];
   logic [COUNT_WIDTH-1:0] tok_best_cnt [SLOTS+1];
   logic [AGE_WIDTH-1:0]   tok_best_age [SLOTS+1];
   logic [ID_WIDTH-1:0]    tok_best_id  [SLOTS+1];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_slots_ff <= CSR_WIDTH'(16);
      end else if (csr_valid) begin
         csr_slots_ff <= csr_slots_in_use;
      end
   end

   assign csr_ext = NW'(csr_slots_ff);

   always_comb begin
      priority if (csr_ext == '0) begin
         active = CNT_W'(1);
      end else if (csr_ext > NW'(SLOTS)) begin
         active = CNT_W'(SLOTS);
      end else begin
         active = CNT_W'(csr_ext);
      end
   end

   assign live = (filled_ff < active) ? filled_ff : active;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The search word enters the chain at cell zero.
   assign tok_flags[0]    = '{valid: accept, hit: 1'b0, best_valid: 1'b0};
   assign tok_id[0]       = req_candidate_id;
   assign tok_hit_idx[0]  = '0;
   assign tok_hit_cnt[0]  = '0;
   assign tok_best_idx[0] = '0;
   assign tok_best_cnt[0] = '0;
   assign tok_best_age[0] = '0;
   assign tok_best_id[0]  = '0;

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      lfust_cell #(
         .INDEX    (k),
         .ID_WIDTH (ID_WIDTH),
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .live         (live),
         .active       (active),
         .flags_in     (tok_flags[k]),
         .id_in        (tok_id[k]),
         .hit_idx_in   (tok_hit_idx[k]),
         .hit_cnt_in   (tok_hit_cnt[k]),
         .best_idx_in  (tok_best_idx[k]),
         .best_cnt_in  (tok_best_cnt[k]),
         .best_age_in  (tok_best_age[k]),
         .best_id_in   (tok_best_id[k]),
         .flags_out    (tok_flags[k+1]),
         .id_out       (tok_id[k+1]),
         .hit_idx_out  (tok_hit_idx[k+1]),
         .hit_cnt_out  (tok_hit_cnt[k+1]),
         .best_idx_out (tok_best_idx[k+1]),
         .best_cnt_out (tok_best_cnt[k+1]),
         .best_age_out (tok_best_age[k+1]),
         .best_id_out  (tok_best_id[k+1]),
         .upd          (upd),
         .upd_slot     (upd_slot),
         .upd_id       (upd_id)
      );
   end

   always_comb begin
      state_in       = state_ff;
      filled_in      = filled_ff;
      pend_slot_in   = pend_slot_ff;
      pend_action_in = pend_action_ff;
      pend_evict_in  = pend_evict_ff;
      pend_count_in  = pend_count_ff;
      pend_id_in     = pend_id_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_evict_in   = rsp_evict_ff;
      rsp_count_in   = rsp_count_ff;
      upd            = '0;
      upd_slot       = pend_slot_ff;
      upd_id         = pend_id_ff;
      slot_wide      = {{SLOT_OUT_WIDTH{1'b0}}, pend_slot_ff};
      evict_wide     = {{EVICT_WIDTH{1'b0}}, pend_evict_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tok_flags[SLOTS].valid) begin
               state_in   = ST_HOLD;
               pend_id_in = tok_id[SLOTS];
               priority if (tok_flags[SLOTS].hit) begin
                  pend_action_in = ACT_HIT;
                  pend_slot_in   = tok_hit_idx[SLOTS];
                  pend_evict_in  = '0;
                  pend_count_in  = (tok_hit_cnt[SLOTS] == COUNT_MAX) ? COUNT_MAX :
                                   tok_hit_cnt[SLOTS] + COUNT_WIDTH'(1);
               end else if (filled_ff < active) begin
                  pend_action_in = ACT_FILL;
                  pend_slot_in   = filled_ff[IDX_W-1:0];
                  pend_evict_in  = '0;
                  pend_count_in  = COUNT_WIDTH'(1);
               end else begin
                  pend_action_in = ACT_REPLACE;
                  pend_slot_in   = tok_best_idx[SLOTS];
                  pend_evict_in  = tok_best_id[SLOTS];
                  pend_count_in  = COUNT_WIDTH'(1);
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               upd.valid     = 1'b1;
               upd.bump      = pend_action_ff == ACT_HIT;
               upd.fill      = pend_action_ff != ACT_HIT;
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = slot_wide[SLOT_OUT_WIDTH-1:0];
               rsp_action_in = pend_action_ff;
               rsp_evict_in  = evict_wide[EVICT_WIDTH-1:0];
               rsp_count_in  = pend_count_ff;
               if (pend_action_ff == ACT_FILL) begin
                  filled_in = filled_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff   <= pend_slot_in;
      pend_action_ff <= pend_action_in;
      pend_evict_ff  <= pend_evict_in;
      pend_count_ff  <= pend_count_in;
      pend_id_ff     <= pend_id_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_evict_ff   <= rsp_evict_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_evicted_id = rsp_evict_ff;
   assign rsp_use_count  = rsp_count_ff;

endmodule

FILE: bench/lfu_slot_table_oldest_tiebreak_checker.sv
module lfu_slot_table_oldest_tiebreak_checker
   import lfust_pkg::*;
#(
   parameter int SLOTS    = 16,
   parameter int ID_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_WIDTH-1:0]      csr_slots_in_use,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [ID_WIDTH-1:0]       req_candidate_id,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [SLOT_OUT_WIDTH-1:0] rsp_slot_index,
   input  logic [ACTION_WIDTH-1:0]   rsp_action,
   input  logic [EVICT_WIDTH-1:0]    rsp_evicted_id,
   input  logic [COUNT_WIDTH-1:0]    rsp_use_count,
   output int                        fail_count,
   output int                        pending_words,
   output int                        hit_words,
   output int                        fill_words,
   output int                        replace_words
);

   typedef struct packed {
      logic [SLOT_OUT_WIDTH-1:0] slot;
      logic [ACTION_WIDTH-1:0]   action;
      logic [EVICT_WIDTH-1:0]    evicted;
      logic [COUNT_WIDTH-1:0]    count;
   } slot_outcome_type;

   logic [CSR_WIDTH-1:0]   slots_setting;
   logic [ID_WIDTH-1:0]    table_ids    [SLOTS];
   logic [COUNT_WIDTH-1:0] table_counts [SLOTS];
   logic [AGE_WIDTH-1:0]   table_ages   [SLOTS];
   int                     filled;
   slot_outcome_type       outcome_q [$];
   int                     mismatches = 0;
   int                     hits = 0;
   int                     fills = 0;
   int                     replaces = 0;

   assign fail_count    = mismatches;
   assign hit_words     = hits;
   assign fill_words    = fills;
   assign replace_words = replaces;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at time %0t: %s", $time, msg);
      mismatches++;
   endtask

   // Looks the id up, updates the table copy and returns what the block must answer.
   function automatic slot_outcome_type reference_word(input logic [ID_WIDTH-1:0] id);
      slot_outcome_type r;
      int               active;
      int               live;
      int               pick;
      bit               found;
      active = (slots_setting == 0) ? 1 : (int'(slots_setting) > SLOTS) ? SLOTS
               : int'(slots_setting);
      live   = (filled < active) ? filled : active;
      found  = 1'b0;
      pick   = 0;
      r      = '0;
      for (int i = 0; i < live; i++) begin
         if (!found && table_ids[i] == id) begin
            found = 1'b1;
            pick  = i;
         end
      end
      if (found) begin
         if (table_counts[pick] != COUNT_MAX) table_counts[pick]++;
         r.action = ACT_HIT;
      end else if (filled < active) begin
         pick = filled;
         filled++;
         table_ids[pick]    = id;
         table_counts[pick] = COUNT_WIDTH'(1);
         table_ages[pick]   = '0;
         r.action = ACT_FILL;
      end else begin
         // Lowest count wins, then the oldest insertion, then the lowest index.
         for (int i = 1; i < active; i++) begin
            if (table_counts[i] < table_counts[pick] ||
                (table_counts[i] == table_counts[pick] && table_ages[i] > table_ages[pick]))
               pick = i;
         end
         r.evicted          = EVICT_WIDTH'(table_ids[pick]);
         table_ids[pick]    = id;
         table_counts[pick] = COUNT_WIDTH'(1);
         table_ages[pick]   = '0;
         r.action = ACT_REPLACE;
      end
      r.slot  = SLOT_OUT_WIDTH'(pick);
      r.count = table_counts[pick];
      for (int i = 0; i < SLOTS; i++) begin
         if (table_ages[i] != AGE_MAX) table_ages[i]++;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      slot_outcome_type want;
      if (reset) begin
         slots_setting = CSR_WIDTH'(16);
         filled        = 0;
         outcome_q.delete();
         for (int i = 0; i < SLOTS; i++) begin
            table_ids[i]    = '0;
            table_counts[i] = '0;
            table_ages[i]   = '0;
         end
      end else begin
         if (csr_valid && csr_ready) slots_setting = csr_slots_in_use;
         if (req_valid && req_ready) outcome_q.push_back(reference_word(req_candidate_id));
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               report_mismatch($sformatf("response word with nothing expected (slot %0d)",
                                         rsp_slot_index));
            end else begin
               want = outcome_q.pop_front();
               if (rsp_slot_index !== want.slot || rsp_action !== want.action ||
                   rsp_evicted_id !== want.evicted || rsp_use_count !== want.count)
                  report_mismatch($sformatf(
                     "got slot %0d action %0d evicted %h count %0d, want %0d %0d %h %0d",
                     rsp_slot_index, rsp_action, rsp_evicted_id, rsp_use_count,
                     want.slot, want.action, want.evicted, want.count));
               unique case (want.action)
                  ACT_HIT:  hits++;
                  ACT_FILL: fills++;
                  default:  replaces++;
               endcase
            end
         end
      end
      pending_words <= outcome_q.size();
   end

endmodule

FILE: bench/lfu_slot_table_oldest_tiebreak_test.sv
module lfu_slot_table_oldest_tiebreak_test;
   import lfust_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 146;

   typedef enum {READY_ALWAYS, READY_RANDOM, READY_WINDOW} ready_mode_type;

   logic                      clock;
   logic                      reset            = 1'b1;
   logic                      csr_valid        = 1'b0;
   logic                      csr_ready;
   logic [CSR_WIDTH-1:0]      csr_slots_in_use = '0;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   logic [15:0]               req_candidate_id = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   logic [SLOT_OUT_WIDTH-1:0] rsp_slot_index;
   logic [ACTION_WIDTH-1:0]   rsp_action;
   logic [EVICT_WIDTH-1:0]    rsp_evicted_id;
   logic [COUNT_WIDTH-1:0]    rsp_use_count;

   int             fail_count;
   int             pending_words;
   int             hit_words;
   int             fill_words;
   int             replace_words;
   int             cycle_count = 0;
   int             settings_used = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left = 0;
   logic [15:0]    id_plan [$];
   logic [4:0]     phase_slots [PHASES];

   lfu_slot_table_oldest_tiebreak i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_slots_in_use (csr_slots_in_use),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_candidate_id (req_candidate_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_action       (rsp_action),
      .rsp_evicted_id   (rsp_evicted_id),
      .rsp_use_count    (rsp_use_count)
   );

   lfu_slot_table_oldest_tiebreak_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_slots_in_use (csr_slots_in_use),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_candidate_id (req_candidate_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_action       (rsp_action),
      .rsp_evicted_id   (rsp_evicted_id),
      .rsp_use_count    (rsp_use_count),
      .fail_count       (fail_count),
      .pending_words    (pending_words),
      .hit_words        (hit_words),
      .fill_words       (fill_words),
      .replace_words    (replace_words)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
                  pending_words);
         $display("lfu_slot_table_oldest_tiebreak test failed");
         $finish;
      end
   end

   // The receiver switches between always ready, random stalls and long stall windows.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 2));
         mode_left  <= $urandom_range(50, 400);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_RANDOM: rsp_ready <= ($urandom_range(0, 3) != 0);
         default:      rsp_ready <= (cycle_count % 29) >= 12;
      endcase
   end

   task automatic write_slots(input logic [4:0] value);
      csr_valid        <= 1'b1;
      csr_slots_in_use <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Sends the planned ids in bursts, then waits until every response word is back.
   task automatic send_plan();
      int burst;
      int gap;
      burst = 0;
      foreach (id_plan[k]) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 16);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst--;
         req_valid        <= 1'b1;
         req_candidate_id <= id_plan[k];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
      end
      req_valid <= 1'b0;
      id_plan.delete();
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Mostly a skewed pool of ids sized to the table, so hits and count ties are common;
   // the rest are fully random ids that nearly always miss.
   function automatic void plan_random_phase(input logic [4:0] setting, input int words);
      logic [15:0] pool [$];
      int          active;
      int          pool_size;
      active    = (setting == 0) ? 1 : (setting > 16) ? 16 : int'(setting);
      pool_size = active + $urandom_range(1, active + 4);
      for (int i = 0; i < pool_size; i++) begin
         case ($urandom_range(0, 15))
            0:       pool.push_back(16'h0000);
            1:       pool.push_back(16'hFFFF);
            default: pool.push_back(16'($urandom_range(0, 65535)));
         endcase
      end
      for (int i = 0; i < words; i++) begin
         if ($urandom_range(0, 9) == 0)
            id_plan.push_back(16'($urandom_range(0, 65535)));
         else
            id_plan.push_back(pool[$urandom_range(0, $urandom_range(0, pool_size - 1))]);
      end
   endfunction

   initial begin
      phase_slots = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd0, 5'd8, 5'd17, 5'd5, 5'd12, 5'd3,
                      5'd16, 5'd0};
      phase_slots[PHASES-1] = 5'($urandom_range(0, 31));
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Three slots: two fills, a hit, a third fill, then replacements where equal counts go to the oldest.
      write_slots(5'd3);
      id_plan = '{16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'hAAAA, 16'h5555};
      send_plan();
      // A setting of zero acts as one slot; the slots above it are neither searched nor
      // replaced.
      write_slots(5'd0);
      id_plan = '{16'h0000, 16'h0007, 16'h0007, 16'h5555};
      send_plan();
      // Raising the setting again fills the free slots above in order.
      write_slots(5'd5);
      id_plan = '{16'h5555, 16'h8001, 16'h7FFE, 16'h0001};
      send_plan();
      // Settings above the slot count act as the full table.
      write_slots(5'd31);
      id_plan = '{16'hFFFF, 16'hC3C3, 16'h3C3C, 16'h0F0F};
      send_plan();

      for (int p = 0; p < PHASES; p++) begin
         write_slots(phase_slots[p]);
         plan_random_phase(phase_slots[p], PHASE_WORDS);
         send_plan();
      end

      $display("Checked %0d response words: %0d hits, %0d fills, %0d replacements.",
               hit_words + fill_words + replace_words, hit_words, fill_words, replace_words);
      $display("The table ran under %0d slot settings, from zero and one up to 31.",
               settings_used);
      if (fail_count == 0)
         $display("lfu_slot_table_oldest_tiebreak test passed");
      else
         $display("lfu_slot_table_oldest_tiebreak test failed");
      $finish;
   end

endmodule
